// ----- rtl/ffha_pkg.sv -----
// Shared types and constants of the first-fit heap allocator.
// Used by ffha_core and first_fit_heap_allocator; depends on nothing.
`default_nettype none

package ffha_pkg;

    localparam int ARENA_BYTES  = 65536;
    localparam int HEADER_BYTES = 20;
    localparam int ALIGN_BYTES  = 8;

    // Field widths of the stream items.
    localparam int OP_W     = 2;
    localparam int SIZE_W   = 17;
    localparam int ADDR_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COPY_W   = 17;
    localparam int IN_DATA_W  = ((SIZE_W + ADDR_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ADDR_W + COPY_W + 7) / 8) * 8;

    // Byte offsets inside the arena; headers always sit on 4-byte boundaries.
    localparam int OFF_W   = $clog2(ARENA_BYTES);
    localparam int DEPTH   = ARENA_BYTES / 4;
    localparam int IDX_W   = OFF_W - 2;
    localparam int SUM_W   = OFF_W + 2;
    localparam int REQ_W   = SIZE_W + 1;
    localparam int CMP_W   = REQ_W + 1;
    localparam int ADDR_MAX = (1 << ADDR_W) - 1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_BADPTR = 2'd2
    } status_t;

    // One header record: the next block follows at offset + header + size.
    typedef struct packed {
        logic             valid;
        logic             free;
        logic             has_prev;
        logic [OFF_W-1:0] prev;
        logic [OFF_W-1:0] size;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] result_address;
        logic [COPY_W-1:0] copy_bytes;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/ffha_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/ffha_core.sv -----
// Sequencer of the allocator: walks, splits and merges block headers held in
// the header RAM. Depends on ffha_pkg and ffha_ram.
`default_nettype none

module ffha_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [ffha_pkg::OP_W-1:0]      in_op,
    input  wire logic [ffha_pkg::SIZE_W-1:0]    in_size,
    input  wire logic [ffha_pkg::ADDR_W-1:0]    in_addr,
    input  wire logic                           out_free,
    output logic                                fin,
    output ffha_pkg::result_t                   result
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_AWALK, S_SPLIT, S_SPRD, S_SPWR, S_HWR, S_FCHK,
        S_MNX, S_MPV, S_MPCHK, S_MPAB, S_RCHK, S_RNX, S_FIN
    } state_t;

    localparam int OFF_W = ffha_pkg::OFF_W;
    localparam int SUM_W = ffha_pkg::SUM_W;
    localparam int REQ_W = ffha_pkg::REQ_W;
    localparam int CMP_W = ffha_pkg::CMP_W;
    localparam int IDX_W = ffha_pkg::IDX_W;

    localparam logic [SUM_W-1:0] HDR_S   = SUM_W'(ffha_pkg::HEADER_BYTES);
    localparam logic [SUM_W-1:0] ARENA_S = SUM_W'(ffha_pkg::ARENA_BYTES);
    localparam logic [SUM_W-1:0] LAST_HDR_S =
        SUM_W'(ffha_pkg::ADDR_MAX - ffha_pkg::HEADER_BYTES);
    localparam logic [REQ_W-1:0] ALIGN_M = REQ_W'(ffha_pkg::ALIGN_BYTES - 1);
    localparam logic [CMP_W-1:0] SPLIT_MIN =
        CMP_W'(ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES);

    state_t                     state_reg, state_next;
    state_t                     ret_reg, ret_next;
    logic [IDX_W-1:0]           clr_reg, clr_next;
    logic                       move_reg, move_next;
    logic [OFF_W-1:0]           h_reg, h_next;
    logic [OFF_W-1:0]           cur_reg, cur_next;
    logic [OFF_W-1:0]           mh_reg, mh_next;
    ffha_pkg::entry_t           ent_reg, ent_next;
    logic [REQ_W-1:0]           req_reg, req_next;
    logic [OFF_W-1:0]           sp_tgt_reg, sp_tgt_next;
    logic [OFF_W-1:0]           sp_val_reg, sp_val_next;
    ffha_pkg::status_t          st_reg, st_next;
    logic [ffha_pkg::ADDR_W-1:0] res_reg, res_next;
    logic [ffha_pkg::COPY_W-1:0] cp_reg, cp_next;

    logic                       we, re;
    logic [IDX_W-1:0]           waddr, raddr;
    ffha_pkg::entry_t           wdata, rd, init_ent;
    logic [ffha_pkg::ENTRY_W-1:0] rdata_raw;

    ffha_ram #(
        .WIDTH (ffha_pkg::ENTRY_W),
        .DEPTH (ffha_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rd = ffha_pkg::entry_t'(rdata_raw);

    always_comb
    begin
        init_ent          = '0;
        init_ent.valid    = 1'b1;
        init_ent.free     = 1'b1;
        init_ent.size     = OFF_W'(ffha_pkg::ARENA_BYTES - ffha_pkg::HEADER_BYTES);
    end

    always_comb
    begin
        logic [SUM_W-1:0]         sum_walk;
        logic [SUM_W-1:0]         sum_rd_h;
        logic [SUM_W-1:0]         sum_ent_h;
        logic [SUM_W-1:0]         sum_tail;
        logic [SUM_W-1:0]         grow;
        logic [SUM_W-1:0]         nn_grow;
        logic [REQ_W-1:0]         req_in;
        logic [ffha_pkg::ADDR_W-1:0] hoff;
        logic                     bad_ptr;
        logic                     start_alloc;
        logic                     start_free;
        logic                     start_move;

        sum_walk  = SUM_W'(cur_reg) + HDR_S + SUM_W'(rd.size);
        sum_rd_h  = SUM_W'(h_reg) + HDR_S + SUM_W'(rd.size);
        sum_ent_h = SUM_W'(h_reg) + HDR_S + SUM_W'(ent_reg.size);
        sum_tail  = SUM_W'(h_reg) + HDR_S + SUM_W'(req_reg);
        grow      = SUM_W'(ent_reg.size) + HDR_S + SUM_W'(rd.size);
        nn_grow   = SUM_W'(h_reg) + HDR_S + grow;
        req_in    = (REQ_W'(in_size) + ALIGN_M) & ~ALIGN_M;
        hoff      = in_addr - ffha_pkg::ADDR_W'(ffha_pkg::HEADER_BYTES);
        bad_ptr   = (SUM_W'(in_addr) < HDR_S) || (hoff[1:0] != 2'b00) ||
                    (SUM_W'(hoff) >= ARENA_S);
        start_alloc = 1'b0;
        start_free  = 1'b0;
        start_move  = 1'b0;

        state_next  = state_reg;
        ret_next    = ret_reg;
        clr_next    = clr_reg;
        move_next   = move_reg;
        h_next      = h_reg;
        cur_next    = cur_reg;
        mh_next     = mh_reg;
        ent_next    = ent_reg;
        req_next    = req_reg;
        sp_tgt_next = sp_tgt_reg;
        sp_val_next = sp_val_reg;
        st_next     = st_reg;
        res_next    = res_reg;
        cp_next     = cp_reg;

        we    = 1'b0;
        waddr = h_reg[OFF_W-1:2];
        wdata = ent_reg;
        re    = 1'b0;
        raddr = '0;
        fin   = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = (clr_reg == '0) ? init_ent : '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    st_next   = ffha_pkg::ST_OK;
                    res_next  = '0;
                    cp_next   = '0;
                    move_next = 1'b0;
                    h_next    = OFF_W'(hoff);
                    case (in_op)
                        ffha_pkg::OP_ALLOC:
                        begin
                            start_alloc = 1'b1;
                        end
                        ffha_pkg::OP_FREE:
                        begin
                            start_free = 1'b1;
                        end
                        ffha_pkg::OP_REALLOC:
                        begin
                            if (in_addr == '0)
                            begin
                                start_alloc = 1'b1;
                            end
                            else if (in_size == '0)
                            begin
                                start_free = 1'b1;
                            end
                            else if (bad_ptr)
                            begin
                                st_next    = ffha_pkg::ST_BADPTR;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                req_next   = req_in;
                                re         = 1'b1;
                                raddr      = hoff[OFF_W-1:2];
                                state_next = S_RCHK;
                            end
                        end
                        default:
                        begin
                            st_next    = ffha_pkg::ST_BADPTR;
                            state_next = S_FIN;
                        end
                    endcase

                    if (start_alloc)
                    begin
                        if (in_size == '0)
                        begin
                            st_next    = ffha_pkg::ST_NOFIT;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            req_next   = req_in;
                            cur_next   = '0;
                            re         = 1'b1;
                            raddr      = '0;
                            state_next = S_AWALK;
                        end
                    end

                    if (start_free)
                    begin
                        if (in_addr == '0)
                        begin
                            state_next = S_FIN;
                        end
                        else if (bad_ptr)
                        begin
                            st_next    = ffha_pkg::ST_BADPTR;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            re         = 1'b1;
                            raddr      = hoff[OFF_W-1:2];
                            state_next = S_FCHK;
                        end
                    end
                end
            end

            S_AWALK:
            begin
                if (rd.free && (REQ_W'(rd.size) >= req_reg))
                begin
                    h_next     = cur_reg;
                    ent_next   = rd;
                    state_next = S_SPLIT;
                end
                else if ((sum_walk > LAST_HDR_S) || (sum_walk >= ARENA_S))
                begin
                    // Nothing fits below the last offset the address field can carry.
                    st_next    = ffha_pkg::ST_NOFIT;
                    res_next   = '0;
                    cp_next    = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    cur_next = OFF_W'(sum_walk);
                    re       = 1'b1;
                    raddr    = sum_walk[OFF_W-1:2];
                end
            end

            S_SPLIT:
            begin
                state_next = S_HWR;
                if (CMP_W'(ent_reg.size) >= CMP_W'(req_reg) + SPLIT_MIN)
                begin
                    we             = 1'b1;
                    wdata          = '0;
                    wdata.valid    = 1'b1;
                    wdata.free     = 1'b1;
                    wdata.has_prev = 1'b1;
                    wdata.prev     = h_reg;
                    wdata.size     = OFF_W'(REQ_W'(ent_reg.size) - req_reg -
                                            REQ_W'(ffha_pkg::HEADER_BYTES));
                    waddr          = sum_tail[OFF_W-1:2];
                    ent_next.size  = OFF_W'(req_reg);
                    // The block after the tail is the one that followed before the split.
                    if (sum_ent_h < ARENA_S)
                    begin
                        sp_tgt_next = OFF_W'(sum_ent_h);
                        sp_val_next = OFF_W'(sum_tail);
                        ret_next    = S_HWR;
                        state_next  = S_SPRD;
                    end
                end
            end

            S_SPRD:
            begin
                re         = 1'b1;
                raddr      = sp_tgt_reg[OFF_W-1:2];
                state_next = S_SPWR;
            end

            S_SPWR:
            begin
                we             = 1'b1;
                waddr          = sp_tgt_reg[OFF_W-1:2];
                wdata          = rd;
                wdata.prev     = sp_val_reg;
                wdata.has_prev = 1'b1;
                state_next     = ret_reg;
            end

            S_HWR:
            begin
                we         = 1'b1;
                wdata      = ent_reg;
                wdata.free = 1'b0;
                res_next   = ffha_pkg::ADDR_W'(SUM_W'(h_reg) + HDR_S);
                if (move_reg)
                begin
                    // Reread the old block: the allocation may have relinked it.
                    h_next     = mh_reg;
                    re         = 1'b1;
                    raddr      = mh_reg[OFF_W-1:2];
                    state_next = S_FCHK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FCHK:
            begin
                if (!rd.valid || rd.free)
                begin
                    st_next    = ffha_pkg::ST_BADPTR;
                    state_next = S_FIN;
                end
                else
                begin
                    ent_next      = rd;
                    ent_next.free = 1'b1;
                    if (sum_rd_h < ARENA_S)
                    begin
                        cur_next   = OFF_W'(sum_rd_h);
                        re         = 1'b1;
                        raddr      = sum_rd_h[OFF_W-1:2];
                        state_next = S_MNX;
                    end
                    else
                    begin
                        state_next = S_MPV;
                    end
                end
            end

            S_MNX:
            begin
                state_next = S_MPV;
                if (rd.free)
                begin
                    ent_next.size = OFF_W'(grow);
                    we            = 1'b1;
                    waddr         = cur_reg[OFF_W-1:2];
                    wdata         = '0;
                    if (nn_grow < ARENA_S)
                    begin
                        sp_tgt_next = OFF_W'(nn_grow);
                        sp_val_next = h_reg;
                        ret_next    = S_MPV;
                        state_next  = S_SPRD;
                    end
                end
            end

            S_MPV:
            begin
                if (ent_reg.has_prev)
                begin
                    re         = 1'b1;
                    raddr      = ent_reg.prev[OFF_W-1:2];
                    state_next = S_MPCHK;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_FIN;
                end
            end

            S_MPCHK:
            begin
                we = 1'b1;
                if (rd.free)
                begin
                    // The previous block swallows this one.
                    wdata         = '0;
                    ent_next      = rd;
                    ent_next.size = OFF_W'(SUM_W'(rd.size) + HDR_S + SUM_W'(ent_reg.size));
                    h_next        = ent_reg.prev;
                    state_next    = S_MPAB;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_MPAB:
            begin
                we         = 1'b1;
                state_next = S_FIN;
                if (sum_ent_h < ARENA_S)
                begin
                    sp_tgt_next = OFF_W'(sum_ent_h);
                    sp_val_next = h_reg;
                    ret_next    = S_FIN;
                    state_next  = S_SPRD;
                end
            end

            S_RCHK:
            begin
                if (!rd.valid || rd.free)
                begin
                    st_next    = ffha_pkg::ST_BADPTR;
                    state_next = S_FIN;
                end
                else
                begin
                    ent_next = rd;
                    if (req_reg <= REQ_W'(rd.size))
                    begin
                        state_next = S_SPLIT;
                    end
                    else if (sum_rd_h < ARENA_S)
                    begin
                        cur_next   = OFF_W'(sum_rd_h);
                        re         = 1'b1;
                        raddr      = sum_rd_h[OFF_W-1:2];
                        state_next = S_RNX;
                    end
                    else
                    begin
                        start_move = 1'b1;
                        cp_next    = ffha_pkg::COPY_W'(rd.size);
                    end
                end
            end

            S_RNX:
            begin
                if (rd.free && (grow >= SUM_W'(req_reg)))
                begin
                    ent_next.size = OFF_W'(grow);
                    we            = 1'b1;
                    waddr         = cur_reg[OFF_W-1:2];
                    wdata         = '0;
                    state_next    = S_SPLIT;
                    if (nn_grow < ARENA_S)
                    begin
                        sp_tgt_next = OFF_W'(nn_grow);
                        sp_val_next = h_reg;
                        ret_next    = S_SPLIT;
                        state_next  = S_SPRD;
                    end
                end
                else
                begin
                    start_move = 1'b1;
                    cp_next    = ffha_pkg::COPY_W'(ent_reg.size);
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (start_move)
        begin
            mh_next    = h_reg;
            move_next  = 1'b1;
            cur_next   = '0;
            re         = 1'b1;
            raddr      = '0;
            state_next = S_AWALK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg   <= S_IDLE;
            clr_reg   <= '0;
            move_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            clr_reg   <= clr_next;
            move_reg  <= move_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg      <= h_next;
        cur_reg    <= cur_next;
        mh_reg     <= mh_next;
        ent_reg    <= ent_next;
        req_reg    <= req_next;
        sp_tgt_reg <= sp_tgt_next;
        sp_val_reg <= sp_val_next;
        st_reg     <= st_next;
        res_reg    <= res_next;
        cp_reg     <= cp_next;
    end

    assign in_ready              = (state_reg == S_IDLE);
    assign result.status         = st_reg;
    assign result.result_address = res_reg;
    assign result.copy_bytes     = cp_reg;

endmodule

`default_nettype wire

// ----- rtl/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator: stream ports and result register.
// Depends on ffha_pkg and ffha_core.
//
//  Channel  | Direction | Contents
//  s_axis   | in        | tuser: operation; tdata: size, address
//  m_axis   | out       | tuser: status; tdata: result_address, copy_bytes
//
// One request is worked at a time. Allocate walks the block chain one header
// per RAM read, and relinks the following block when a split leaves a tail.
// Free merges with free neighbours; a null or rejected pointer goes straight
// to the result. A moving reallocate is an allocate plus a free.
// After reset a clearing pass writes all 16384 header RAM entries; no
// request is accepted until it ends. A new request is accepted while a
// result still waits in the output register; the sequencer holds its last
// step until that register is free.
`default_nettype none

module first_fit_heap_allocator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // size [16:0], address [32:17], zero fill above
    input  wire logic [ffha_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation [1:0]
    input  wire logic [ffha_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // result_address [15:0], copy_bytes [32:16], zero fill above
    output logic      [ffha_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status [1:0]
    output logic      [ffha_pkg::STATUS_W-1:0]       m_axis_tuser
);

    localparam int SW = ffha_pkg::SIZE_W;
    localparam int AW = ffha_pkg::ADDR_W;
    localparam int CW = ffha_pkg::COPY_W;

    logic              fin;
    logic              out_free;
    ffha_pkg::result_t result;
    ffha_pkg::result_t out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    assign out_free = !out_valid_reg || m_axis_tready;

    ffha_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .in_size  (s_axis_tdata[SW-1:0]),
        .in_addr  (s_axis_tdata[SW+AW-1:SW]),
        .out_free (out_free),
        .fin      (fin),
        .result   (result)
    );

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (fin)
        begin
            out_next       = result;
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {{(ffha_pkg::OUT_DATA_W - AW - CW){1'b0}},
                            out_reg.copy_bytes, out_reg.result_address};

    // A result is only handed over when the output register can take it.
    a_fin_slot: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> out_free)
        else $error("result finished while output register was occupied");

    // The sequencer never accepts a transaction in the cycle it finishes one.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(fin && s_axis_tvalid && s_axis_tready))
        else $error("accept and finish in the same cycle");

    // A finished result shows up on the output in the next cycle.
    a_fin_shows: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> m_axis_tvalid)
        else $error("finished result missing on output");

    // Rejected pointers never come with a granted address.
    a_bad_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ffha_pkg::ST_BADPTR)) |->
        (m_axis_tdata[AW-1:0] == '0))
        else $error("rejected transaction carries an address");

endmodule

`default_nettype wire

// ----- test/first_fit_heap_allocator_tb.sv -----
// Testbench of first_fit_heap_allocator: drives allocate, free and reallocate requests
// and checks every result against a behavioral block-chain model kept in the bench.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL.
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;

    localparam int WAIT_LIMIT = 20000000;

    localparam int ARENA_BYTES  = ffha_pkg::ARENA_BYTES;
    localparam int HEADER_BYTES = ffha_pkg::HEADER_BYTES;
    localparam int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES;
    localparam int OP_W         = ffha_pkg::OP_W;
    localparam int SIZE_W       = ffha_pkg::SIZE_W;
    localparam int ADDR_W       = ffha_pkg::ADDR_W;
    localparam int STATUS_W     = ffha_pkg::STATUS_W;
    localparam int COPY_W       = ffha_pkg::COPY_W;
    localparam int IN_DATA_W    = ffha_pkg::IN_DATA_W;
    localparam int OUT_DATA_W   = ffha_pkg::OUT_DATA_W;

    localparam ffha_pkg::op_t     OP_ALLOC   = ffha_pkg::OP_ALLOC;
    localparam ffha_pkg::op_t     OP_FREE    = ffha_pkg::OP_FREE;
    localparam ffha_pkg::op_t     OP_REALLOC = ffha_pkg::OP_REALLOC;
    // The one operation code the block does not define.
    localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
    localparam ffha_pkg::status_t ST_OK      = ffha_pkg::ST_OK;
    localparam ffha_pkg::status_t ST_NOFIT   = ffha_pkg::ST_NOFIT;
    localparam ffha_pkg::status_t ST_BADPTR  = ffha_pkg::ST_BADPTR;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic [COPY_W-1:0]   copy;
    } heap_result_t;

    typedef struct {
        int  size;
        int  prev;
        bit  valid;
        bit  is_free;
        bit  has_prev;
    } hdr_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    hdr_t         heap[ARENA_BYTES];
    heap_result_t pending_results[$];
    int           live_blocks[$];
    int           errors;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           hold_receiver;
    int           hold_cycles;
    longint       cycle_count;

    first_fit_heap_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > WAIT_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic int round_up(int n);
        return ((n + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic bit next_hdr(int h, output int n);
        int x;
        x = h + HEADER_BYTES + heap[h].size;
        n = x;
        return x < ARENA_BYTES;
    endfunction

    function automatic int decode_ptr(int addr);
        int h;
        if (addr < HEADER_BYTES)
            return -1;
        h = addr - HEADER_BYTES;
        if (h >= ARENA_BYTES || !heap[h].valid)
            return -1;
        return h;
    endfunction

    function automatic void carve_tail(int h, int req);
        int nh;
        int nn;
        if (heap[h].size < req + HEADER_BYTES + ALIGN_BYTES)
            return;
        nh = h + HEADER_BYTES + req;
        heap[nh].valid = 1;
        heap[nh].is_free = 1;
        heap[nh].size = heap[h].size - req - HEADER_BYTES;
        heap[nh].prev = h;
        heap[nh].has_prev = 1;
        heap[h].size = req;
        if (next_hdr(nh, nn))
        begin
            heap[nn].prev = nh;
            heap[nn].has_prev = 1;
        end
    endfunction

    function automatic void absorb_next(int h, int n);
        int nn;
        heap[h].size += HEADER_BYTES + heap[n].size;
        heap[n] = '{0, 0, 0, 0, 0};
        if (next_hdr(h, nn))
        begin
            heap[nn].prev = h;
            heap[nn].has_prev = 1;
        end
    endfunction

    function automatic void merge_free(int h);
        int n;
        int p;
        if (next_hdr(h, n) && heap[n].is_free)
            absorb_next(h, n);
        if (heap[h].has_prev)
        begin
            p = heap[h].prev;
            if (p < ARENA_BYTES && heap[p].is_free)
                absorb_next(p, h);
        end
    endfunction

    function automatic int first_fit(int size);
        int cur;
        int req;
        cur = 0;
        if (size == 0)
            return 0;
        req = round_up(size);
        forever
        begin
            if (cur + HEADER_BYTES > 16'hFFFF)
                return 0;
            if (heap[cur].is_free && heap[cur].size >= req)
                break;
            if (!next_hdr(cur, cur))
                return 0;
        end
        carve_tail(cur, req);
        heap[cur].is_free = 0;
        return cur + HEADER_BYTES;
    endfunction

    function automatic int release_block(int addr);
        int h;
        if (addr == 0)
            return ST_OK;
        h = decode_ptr(addr);
        if (h < 0 || heap[h].is_free)
            return ST_BADPTR;
        heap[h].is_free = 1;
        merge_free(h);
        return ST_OK;
    endfunction

    function automatic heap_result_t predict_heap_op(logic [OP_W-1:0] op, int size,
                                                     int addr);
        heap_result_t r;
        int h;
        int req;
        int n;
        int old;
        r = '{ST_OK, '0, '0};
        if (op == OP_ALLOC || (op == OP_REALLOC && addr == 0))
        begin
            r.addr = ADDR_W'(first_fit(size));
            r.status = (r.addr != 0) ? ST_OK : ST_NOFIT;
        end
        else if (op == OP_FREE || (op == OP_REALLOC && size == 0))
            r.status = STATUS_W'(release_block(addr));
        else if (op == OP_REALLOC)
        begin
            h = decode_ptr(addr);
            if (h < 0 || heap[h].is_free)
                r.status = ST_BADPTR;
            else
            begin
                req = round_up(size);
                if (req <= heap[h].size)
                begin
                    carve_tail(h, req);
                    r.addr = ADDR_W'(addr);
                end
                else if (next_hdr(h, n) && heap[n].is_free
                         && heap[h].size + HEADER_BYTES + heap[n].size >= req)
                begin
                    absorb_next(h, n);
                    carve_tail(h, req);
                    r.addr = ADDR_W'(addr);
                end
                else
                begin
                    old = heap[h].size;
                    r.addr = ADDR_W'(first_fit(req));
                    if (r.addr == 0)
                        r.status = ST_NOFIT;
                    else
                    begin
                        r.copy = COPY_W'(old);
                        heap[h].is_free = 1;
                        merge_free(h);
                    end
                end
            end
        end
        else
            r.status = ST_BADPTR;
        return r;
    endfunction

    // Sends one request; the expectation is queued when the transaction completes.
    // The valid line stays high between back-to-back requests.
    task automatic send_request(logic [OP_W-1:0] op, int size, int addr);
        heap_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_DATA_W'({addr[ADDR_W-1:0], size[SIZE_W-1:0]});
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = predict_heap_op(op, size, addr);
        pending_results.push_back(r);
        if (r.addr != 0)
            live_blocks.push_back(r.addr);
        @(negedge clk);
    endtask

    function automatic int pick_pointer();
        int i;
        if (live_blocks.size() == 0)
            return 0;
        i = $urandom_range(live_blocks.size() - 1);
        pick_pointer = live_blocks[i];
        live_blocks.delete(i);
    endfunction

    function automatic int random_size();
        case ($urandom_range(9))
            0:       return $urandom_range(65536);
            1, 2:    return $urandom_range(2048);
            default: return $urandom_range(1, 300);
        endcase
    endfunction

    task automatic test_directed();
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_ALLOC, 1, 0);
        send_request(OP_ALLOC, 8, 0);
        send_request(OP_ALLOC, 65536, 0);
        send_request(OP_ALLOC, 100, 0);
        send_request(OP_FREE, 0, 0);
        send_request(OP_FREE, 0, 5);
        send_request(OP_FREE, 0, 16'hFFFF);
        send_request(OP_FREE, 0, 20);
        send_request(OP_FREE, 0, 20);
        send_request(OP_REALLOC, 40, 0);
        send_request(OP_REALLOC, 4, 48);
        send_request(OP_REALLOC, 200, 48);
        send_request(OP_REALLOC, 0, 48);
        send_request(OP_REALLOC, 8, 48);
        send_request(OP_UNUSED, 8, 20);
        send_request(OP_ALLOC, 65516, 0);
        send_request(OP_ALLOC, 8, 0);
        send_request(OP_REALLOC, 1000, 20);
        send_request(OP_FREE, 0, 20);
        send_request(OP_ALLOC, 65500, 0);
        send_request(OP_REALLOC, 65516, 20);
        send_request(OP_REALLOC, 131071, 20);
        send_request(OP_FREE, 0, 20);
        live_blocks.delete();
    endtask

    task automatic test_random(int count);
        int k;
        int p;
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(19))
                0:
                    send_request(OP_FREE, 0, $urandom_range(16'hFFFF));
                1:
                    send_request($urandom_range(3), $urandom_range(17'h1FFFF),
                                 $urandom_range(16'hFFFF));
                2, 3, 4, 5, 6, 7, 8:
                    send_request(OP_ALLOC, random_size(), 0);
                9, 10, 11, 12, 13, 14:
                    send_request(OP_FREE, 0, pick_pointer());
                default:
                begin
                    p = pick_pointer();
                    send_request(OP_REALLOC, ($urandom_range(9) == 0) ? 0 : random_size(), p);
                end
            endcase
        end
    endtask

    // The receiver stalls for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        hold_cycles = 400;
        hold_receiver = 1'b1;
        test_random(20);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_receiver)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_receiver = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        heap_result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with no request pending");
                    errors++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (m_axis_tuser !== exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[ADDR_W-1:0] !== exp_r.addr)
                    begin
                        $error("result_address: expected %0d, got %0d",
                               exp_r.addr, m_axis_tdata[ADDR_W-1:0]);
                        errors++;
                    end
                    if (m_axis_tdata[ADDR_W+COPY_W-1:ADDR_W] !== exp_r.copy)
                    begin
                        $error("copy_bytes: expected %0d, got %0d",
                               exp_r.copy, m_axis_tdata[ADDR_W+COPY_W-1:ADDR_W]);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        hold_receiver = 1'b0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        foreach (heap[i])
            heap[i] = '{0, 0, 0, 0, 0};
        heap[0] = '{ARENA_BYTES - HEADER_BYTES, 0, 1, 1, 0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        send_idle_pct = 15;
        recv_idle_pct = 88;
        test_random(230);
        test_output_backpressure();
        send_idle_pct = 88;
        recv_idle_pct = 15;
        test_random(230);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(230);
        wait_drained();

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
